[src/tkl_pkg.sv]
// Shared types, byte codes and token kinds for the terminal key lexer.
package tkl_pkg;

  localparam int TKL_MODIFIER_LIMIT = 16;
  localparam int TKL_FIFO_DEPTH     = 4;

  typedef enum logic [3:0] {
    TK_END       = 4'd0,
    TK_TEXT      = 4'd1,
    TK_UNSUP     = 4'd2,
    TK_INTR      = 4'd3,
    TK_ACCEPT    = 4'd4,
    TK_ESCAPE    = 4'd5,
    TK_BACKSPACE = 4'd6,
    TK_DELETE    = 4'd7,
    TK_UP        = 4'd8,
    TK_DOWN      = 4'd9,
    TK_RIGHT     = 4'd10,
    TK_LEFT      = 4'd11,
    TK_HOME      = 4'd12,
    TK_ENDKEY    = 4'd13
  } tkl_kind_t;

  typedef struct packed {
    logic        valid;
    tkl_kind_t   kind;
    logic [20:0] cp;
    logic        last;
  } tkl_tok_t;

  localparam logic [7:0] CH_ETX      = 8'h03;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_F        = 8'h46;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_DEL      = 8'h7F;

  // Kind of a single ASCII byte (ESC handled by the caller).
  function automatic tkl_kind_t ascii_kind(input logic [7:0] b);
    tkl_kind_t k;
    k = TK_UNSUP;
    if (b == CH_ETX) k = TK_INTR;
    else if (b == CH_BS) k = TK_DELETE;
    else if (b == CH_DEL) k = TK_BACKSPACE;
    else if (b == CH_LF || b == CH_CR) k = TK_ACCEPT;
    else if (b inside {[CH_SPACE:CH_TILDE]}) k = TK_TEXT;
    return k;
  endfunction

endpackage

[src/tkl_lexer.sv]
// Lexer state and per-byte decode: up to two tokens per item.
module tkl_lexer import tkl_pkg::*; #(
  parameter int MODIFIER_LIMIT = TKL_MODIFIER_LIMIT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       buffer_end,
  output tkl_tok_t   tok0,
  output tkl_tok_t   tok1
);

  localparam int CW = $clog2(MODIFIER_LIMIT + 1);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_UTF8    = 5'b00010,
    PH_ESC     = 5'b00100,
    PH_CSI     = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [20:0]     acc_r, acc_nxt;
  logic [1:0]      left_r, left_nxt;
  logic [CW-1:0]   mcount_r, mcount_nxt;
  logic [7:0]      mval_r, mval_nxt;
  logic            mneg_r, mneg_nxt;
  logic            innum_r, innum_nxt;

  // idle-byte decode, shared by the idle and after-ESC paths
  tkl_tok_t        idle_tok;
  phase_t          idle_phase;
  logic [20:0]     idle_acc;
  logic [1:0]      idle_left;

  logic [20:0]     acc_shift;
  logic [1:0]      left_dec;
  logic            digit;
  logic [11:0]     mval_mac;
  tkl_kind_t       fin_kind;
  tkl_tok_t        t0, t1;

  always_comb begin
    idle_tok   = '0;
    idle_phase = PH_IDLE;
    idle_acc   = acc_r;
    idle_left  = left_r;
    if (!data_byte[7]) begin
      if (data_byte == CH_ESC) begin
        idle_phase = PH_ESC;
      end else begin
        idle_tok.valid = 1'b1;
        idle_tok.kind  = ascii_kind(data_byte);
        idle_tok.cp    = (ascii_kind(data_byte) == TK_TEXT) ? {13'd0, data_byte} : 21'd0;
      end
    end else if (data_byte inside {[8'hC2:8'hDF]}) begin
      idle_acc   = {16'd0, data_byte[4:0]};
      idle_left  = 2'd1;
      idle_phase = PH_UTF8;
    end else if (data_byte inside {[8'hE0:8'hEF]}) begin
      idle_acc   = {17'd0, data_byte[3:0]};
      idle_left  = 2'd2;
      idle_phase = PH_UTF8;
    end else if (data_byte inside {[8'hF0:8'hF4]}) begin
      idle_acc   = {18'd0, data_byte[2:0]};
      idle_left  = 2'd3;
      idle_phase = PH_UTF8;
    end else begin
      idle_tok.valid = 1'b1;
      idle_tok.kind  = TK_END;
      idle_phase     = PH_DISCARD;
    end
  end

  assign acc_shift = {acc_r[14:0], data_byte[5:0]};
  assign left_dec  = left_r - 2'd1;
  assign digit     = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign mval_mac  = {4'd0, mval_r} * 12'd10 + {8'd0, data_byte[3:0]};

  // final byte of a control sequence
  always_comb begin
    case (data_byte)
      CH_A:     fin_kind = TK_UP;
      CH_B:     fin_kind = TK_DOWN;
      CH_C:     fin_kind = TK_RIGHT;
      CH_D:     fin_kind = TK_LEFT;
      CH_F:     fin_kind = TK_ENDKEY;
      CH_H:     fin_kind = TK_HOME;
      CH_TILDE: begin
        fin_kind = TK_UNSUP;
        if (mcount_r != '0 && !mneg_r) begin
          case (mval_r)
            8'd1, 8'd7: fin_kind = TK_HOME;
            8'd3:       fin_kind = TK_DELETE;
            8'd4, 8'd8: fin_kind = TK_ENDKEY;
            default:    fin_kind = TK_UNSUP;
          endcase
        end
      end
      default:  fin_kind = TK_UNSUP;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    left_nxt   = left_r;
    mcount_nxt = mcount_r;
    mval_nxt   = mval_r;
    mneg_nxt   = mneg_r;
    innum_nxt  = innum_r;
    t0         = '0;
    t1         = '0;

    if (buffer_end) begin
      case (phase_r)
        PH_ESC: begin
          t0.valid = 1'b1; t0.kind = TK_ESCAPE;
          t1.valid = 1'b1; t1.kind = TK_END;
        end
        PH_CSI: begin
          t0.valid = 1'b1; t0.kind = TK_UNSUP;
          t1.valid = 1'b1; t1.kind = TK_END;
        end
        PH_DISCARD: ;
        default: begin
          t0.valid = 1'b1; t0.kind = TK_END;
        end
      endcase
      phase_nxt  = PH_IDLE;
      acc_nxt    = '0;
      left_nxt   = '0;
      mcount_nxt = '0;
      mval_nxt   = '0;
      mneg_nxt   = 1'b0;
      innum_nxt  = 1'b0;
    end else begin
      case (phase_r)
        PH_UTF8: begin
          if (data_byte[7:6] != 2'b10) begin
            t0.valid  = 1'b1; t0.kind = TK_END;
            phase_nxt = PH_DISCARD;
          end else begin
            acc_nxt  = acc_shift;
            left_nxt = left_dec;
            if (left_dec == 2'd0) begin
              if (acc_shift < 21'h80 || acc_shift > 21'h10FFFF) begin
                t0.valid  = 1'b1; t0.kind = TK_END;
                phase_nxt = PH_DISCARD;
              end else begin
                t0.valid  = 1'b1; t0.kind = TK_TEXT; t0.cp = acc_shift;
                phase_nxt = PH_IDLE;
              end
            end
          end
        end
        PH_ESC: begin
          if (data_byte == CH_LBRACKET) begin
            phase_nxt  = PH_CSI;
            mcount_nxt = '0;
            mval_nxt   = '0;
            mneg_nxt   = 1'b0;
            innum_nxt  = 1'b0;
          end else begin
            // lone ESC, then the byte is lexed afresh
            t0.valid  = 1'b1; t0.kind = TK_ESCAPE;
            t1        = idle_tok;
            phase_nxt = idle_phase;
            acc_nxt   = idle_acc;
            left_nxt  = idle_left;
          end
        end
        PH_CSI: begin
          if (data_byte == CH_MINUS || (digit && !innum_r)) begin
            if (mcount_r >= CW'(MODIFIER_LIMIT)) begin
              t0.valid  = 1'b1; t0.kind = TK_UNSUP;
              phase_nxt = PH_IDLE;
            end else begin
              mcount_nxt = mcount_r + CW'(1);
              innum_nxt  = 1'b1;
              if (mcount_r == '0) begin
                mval_nxt = digit ? {4'd0, data_byte[3:0]} : 8'd0;
                mneg_nxt = (data_byte == CH_MINUS);
              end
            end
          end else if (digit) begin
            if (mcount_r == CW'(1)) begin
              mval_nxt = (mval_mac > 12'd255) ? 8'd255 : mval_mac[7:0];
            end
          end else if (data_byte == CH_SEMI) begin
            innum_nxt = 1'b0;
          end else begin
            t0.valid  = 1'b1; t0.kind = fin_kind;
            phase_nxt = PH_IDLE;
          end
        end
        PH_DISCARD: ;
        default: begin
          t0        = idle_tok;
          phase_nxt = idle_phase;
          acc_nxt   = idle_acc;
          left_nxt  = idle_left;
        end
      endcase
    end

    if (t1.valid) t1.last = 1'b1;
    else if (t0.valid) t0.last = 1'b1;
  end

  assign tok0 = t0;
  assign tok1 = t1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      acc_r    <= '0;
      left_r   <= '0;
      mcount_r <= '0;
      mval_r   <= '0;
      mneg_r   <= 1'b0;
      innum_r  <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      left_r   <= left_nxt;
      mcount_r <= mcount_nxt;
      mval_r   <= mval_nxt;
      mneg_r   <= mneg_nxt;
      innum_r  <= innum_nxt;
    end
  end

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    tok1.valid |-> tok0.valid)
    else $error("second token without a first");

  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    fire && phase_r == PH_DISCARD && !buffer_end |-> !tok0.valid)
    else $error("token produced while discarding");

  a_marker_idles: assert property (@(posedge clk) disable iff (!rst_n)
    fire && buffer_end |=> phase_r == PH_IDLE)
    else $error("end marker did not return lexer to idle");

endmodule

[src/tkl_tok_fifo.sv]
// Token queue: takes up to two tokens a cycle, hands out one.
module tkl_tok_fifo import tkl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_en,
  input  tkl_tok_t tok0,
  input  tkl_tok_t tok1,
  output logic     room,
  output logic     out_valid,
  input  logic     out_ready,
  output tkl_tok_t head
);

  localparam int DEPTH = TKL_FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  tkl_tok_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   count_r, count_nxt;
  logic            w0, w1, pop;
  logic [1:0]      push_n;

  assign w0     = push_en && tok0.valid;
  assign w1     = push_en && tok1.valid;
  assign push_n = {1'b0, w0} + {1'b0, w1};
  assign pop    = out_valid && out_ready;

  assign wr_ptr_nxt = wr_ptr_r + PW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign count_nxt  = count_r + NW'(push_n) - NW'(pop);

  assign room      = count_r <= NW'(DEPTH - 2);
  assign out_valid = count_r != '0;
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (w0) mem[wr_ptr_r] <= tok0;
    if (w1) mem[wr_ptr_r + PW'(1)] <= tok1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    w0 |-> count_r <= NW'(DEPTH - 2))
    else $error("token queue written without room for two");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(DEPTH))
    else $error("token queue count out of range");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    w1 |-> w0)
    else $error("second token written without the first");

endmodule

[src/terminal_key_input_lexer.sv]
// Top level of the terminal key lexer: input register, lexer and token queue.
//
// Slave stream in_*: one raw terminal byte per item in in_tdata; an item with
// in_tlast high carries no byte and marks the end of an input buffer.
// Master stream out_*: key tokens, kind and code point in out_tdata, with
// out_tlast high on the final token caused by one input item. An item gives
// zero, one or two tokens.
// A token passes through the input register, then the lexer decode into the
// token queue, before it is offered; the item waits in the input register
// while the queue lacks room.
// Throughput: one item per cycle while the receiver keeps up; the limit is
// the four-entry token queue, which must have room for two tokens before
// the lexer consumes the registered item.
// Reset (rst_n low, synchronous) empties the queue and returns the lexer to
// idle. When the receiver stalls, tokens wait in the queue; once it holds
// more than two, the lexer holds its item and in_tready drops, with no token
// lost or repeated.
module terminal_key_input_lexer import tkl_pkg::*; #(
  parameter int MODIFIER_LIMIT = TKL_MODIFIER_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // buffer_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [3:0] token_kind, [24:4] text_codepoint, rest zero
  output logic        out_tlast   // last_of_run
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       in_take;
  logic       room;
  logic       fire;       // lexer consumes the registered item
  tkl_tok_t   tok0, tok1;
  tkl_tok_t   head;

  assign fire      = in_valid_r && room;
  assign in_tready = !in_valid_r || fire;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) in_valid_nxt = 1'b1;
    else if (fire) in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  tkl_lexer #(
    .MODIFIER_LIMIT(MODIFIER_LIMIT)
  ) u_lexer (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .data_byte  (in_byte_r),
    .buffer_end (in_end_r),
    .tok0       (tok0),
    .tok1       (tok1)
  );

  tkl_tok_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (fire),
    .tok0      (tok0),
    .tok1      (tok1),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head      (head)
  );

  assign out_tdata = {7'd0, head.cp, head.kind};
  assign out_tlast = head.last;

endmodule
